// ===== design/gcd_pkg.sv =====
// Shared types, constants and the arctangent table of the great-circle distance core.
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int DIST_W = 25;
  localparam int CFG_W  = 29;

  // datapath width of the CORDIC units, Q30 with headroom
  localparam int DW = 34;

  // integer square root: 61-bit radicand, 31-bit root, one result bit per step
  localparam int SQ_W     = 61;
  localparam int RT_W     = 31;
  localparam int SQ_STEPS = 31;

  localparam logic signed [DW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic [28:0]          RAD_SCALE       = 29'd314410567;
  localparam logic [23:0]          EARTH_DIAM_M    = 24'd12742000;
  localparam logic [DIST_W-1:0]    MAX_DISTANCE    = 25'd20015087;

  localparam logic signed [29:0] LAT_LIMIT = 30'sd90000000;
  localparam logic signed [29:0] LON_LIMIT = 30'sd180000000;
  localparam logic signed [29:0] FULL_TURN = 30'sd360000000;

  localparam logic [SQ_W-1:0] Q60_ONE = 61'h1000_0000_0000_0000;

  // register indexes
  localparam logic REG_REF_LAT = 1'b0;
  localparam logic REG_REF_LON = 1'b1;

  typedef struct packed {
    logic valid;
    logic err;
  } tag_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage
`default_nettype wire

// ===== design/gcd_cordic_rot.sv =====
// Pipelined rotation-mode CORDIC over several lanes: one micro-rotation per stage.
`default_nettype none
module gcd_cordic_rot #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF,
  parameter int LANES  = 4
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  gcd_pkg::tag_t                       in_tag,
  input  wire logic signed [gcd_pkg::DW-1:0]  in_angle [LANES],
  output gcd_pkg::tag_t                       out_tag,
  output logic signed [gcd_pkg::DW-1:0]       out_sin [LANES],
  output logic signed [gcd_pkg::DW-1:0]       out_cos [LANES]
);

  localparam int DW = gcd_pkg::DW;
  localparam int NS = (STAGES > 32) ? 32 : STAGES;

  logic signed [DW-1:0] x_r [NS][LANES];
  logic signed [DW-1:0] y_r [NS][LANES];
  logic signed [DW-1:0] z_r [NS][LANES];
  gcd_pkg::tag_t        tag_r [NS];

  genvar s, l;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tag_r[s] <= '0;
          end else begin
            tag_r[s] <= in_tag;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tag_r[s] <= '0;
          end else begin
            tag_r[s] <= tag_r[s-1];
          end
        end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
        logic signed [DW-1:0] xi, yi, zi;
        logic signed [DW-1:0] at;

        if (s == 0) begin : g_src0
          assign xi = gcd_pkg::CORDIC_GAIN_INV;
          assign yi = '0;
          assign zi = in_angle[l];
        end else begin : g_srcn
          assign xi = x_r[s-1][l];
          assign yi = y_r[s-1][l];
          assign zi = z_r[s-1][l];
        end

        assign at = signed'({{(DW-32){1'b0}}, gcd_pkg::ATAN_TAB[s]});

        always_ff @(posedge clk) begin
          if (!zi[DW-1]) begin
            x_r[s][l] <= xi - (yi >>> s);
            y_r[s][l] <= yi + (xi >>> s);
            z_r[s][l] <= zi - at;
          end else begin
            x_r[s][l] <= xi + (yi >>> s);
            y_r[s][l] <= yi - (xi >>> s);
            z_r[s][l] <= zi + at;
          end
        end
      end
    end

    for (l = 0; l < LANES; l++) begin : g_out
      assign out_sin[l] = y_r[NS-1][l];
      assign out_cos[l] = x_r[NS-1][l];
    end
  endgenerate

  assign out_tag = tag_r[NS-1];

endmodule
`default_nettype wire

// ===== design/gcd_isqrt.sv =====
// Pipelined integer square root (floor) over several lanes: one root bit per stage.
`default_nettype none
module gcd_isqrt #(
  parameter int LANES = 2
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  gcd_pkg::tag_t                      in_tag,
  input  wire logic [gcd_pkg::SQ_W-1:0]      in_n [LANES],
  output gcd_pkg::tag_t                      out_tag,
  output logic [gcd_pkg::RT_W-1:0]           out_root [LANES]
);

  localparam int W  = gcd_pkg::SQ_W;
  localparam int NS = gcd_pkg::SQ_STEPS;

  logic [W-1:0]  n_r   [NS][LANES];
  logic [W-1:0]  res_r [NS][LANES];
  gcd_pkg::tag_t tag_r [NS];

  genvar s, l;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2 * s);

      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tag_r[s] <= '0;
          end else begin
            tag_r[s] <= in_tag;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tag_r[s] <= '0;
          end else begin
            tag_r[s] <= tag_r[s-1];
          end
        end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
        logic [W-1:0] ni, ri, trial;

        if (s == 0) begin : g_src0
          assign ni = in_n[l];
          assign ri = '0;
        end else begin : g_srcn
          assign ni = n_r[s-1][l];
          assign ri = res_r[s-1][l];
        end

        assign trial = ri + BIT;

        always_ff @(posedge clk) begin
          if (ni >= trial) begin
            n_r[s][l]   <= ni - trial;
            res_r[s][l] <= (ri >> 1) + BIT;
          end else begin
            n_r[s][l]   <= ni;
            res_r[s][l] <= ri >> 1;
          end
        end
      end
    end

    for (l = 0; l < LANES; l++) begin : g_out
      assign out_root[l] = res_r[NS-1][l][gcd_pkg::RT_W-1:0];
    end
  endgenerate

  assign out_tag = tag_r[NS-1];

endmodule
`default_nettype wire

// ===== design/gcd_cordic_vec.sv =====
// Pipelined vectoring-mode CORDIC: angle of (x, y), one micro-rotation per stage.
`default_nettype none
module gcd_cordic_vec #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  gcd_pkg::tag_t                      in_tag,
  input  wire logic signed [gcd_pkg::DW-1:0] in_x,
  input  wire logic signed [gcd_pkg::DW-1:0] in_y,
  output gcd_pkg::tag_t                      out_tag,
  output logic signed [gcd_pkg::DW-1:0]      out_angle
);

  localparam int DW = gcd_pkg::DW;
  localparam int NS = (STAGES > 32) ? 32 : STAGES;

  logic signed [DW-1:0] x_r [NS];
  logic signed [DW-1:0] y_r [NS];
  logic signed [DW-1:0] z_r [NS];
  gcd_pkg::tag_t        tag_r [NS];

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      logic signed [DW-1:0] xi, yi, zi;
      logic signed [DW-1:0] at;
      gcd_pkg::tag_t        ti;

      if (s == 0) begin : g_src0
        assign xi = in_x;
        assign yi = in_y;
        assign zi = '0;
        assign ti = in_tag;
      end else begin : g_srcn
        assign xi = x_r[s-1];
        assign yi = y_r[s-1];
        assign zi = z_r[s-1];
        assign ti = tag_r[s-1];
      end

      assign at = signed'({{(DW-32){1'b0}}, gcd_pkg::ATAN_TAB[s]});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[s] <= '0;
        end else begin
          tag_r[s] <= ti;
        end
      end

      // drive y toward zero, accumulate the angle
      always_ff @(posedge clk) begin
        if (!yi[DW-1]) begin
          x_r[s] <= xi + (yi >>> s);
          y_r[s] <= yi - (xi >>> s);
          z_r[s] <= zi + at;
        end else begin
          x_r[s] <= xi - (yi >>> s);
          y_r[s] <= yi + (xi >>> s);
          z_r[s] <= zi - at;
        end
      end
    end
  endgenerate

  assign out_tag   = tag_r[NS-1];
  assign out_angle = z_r[NS-1];

endmodule
`default_nettype wire

// ===== design/great_circle_distance_core.sv =====
// Top level: haversine great-circle distance from a position fix to a reference point.
//
// Usage: write the reference latitude (index 0) and longitude (index 1), in signed
// microdegrees, through cfg_we / cfg_index / cfg_wdata while no fix is in flight.
// Present a fix on in_fix_latitude / in_fix_longitude with start high; busy stays
// low, so one fix is taken on every clock edge with start high.
// Each fix gives one word on out_distance_m / out_range_error, marked by a
// one-cycle out_valid pulse. The result passes through the two CORDIC pipelines
// and the 31-step square-root pipeline; throughput is one fix per cycle.
// A coordinate outside +/-90 degrees latitude or +/-180 degrees longitude, in the
// fix or in the reference, gives range_error = 1 and distance 0.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset empties the pipeline and loads the default reference point.
`default_nettype none
module great_circle_distance_core #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire                                   cfg_index,
  input  wire [gcd_pkg::CFG_W-1:0]              cfg_wdata,
  input  wire                                   start,
  output logic                                  busy,
  input  wire logic signed [gcd_pkg::LAT_W-1:0] in_fix_latitude,
  input  wire logic signed [gcd_pkg::LON_W-1:0] in_fix_longitude,
  output logic                                  out_valid,
  output logic [gcd_pkg::DIST_W-1:0]            out_distance_m,
  output logic                                  out_range_error
);

  localparam int DW  = gcd_pkg::DW;
  localparam int PW  = 2 * DW;
  localparam logic signed [PW-1:0] HALF_Q30 = PW'(1) << 29;
  localparam logic [56:0]          HALF_D   = 57'(1) << 29;

  // reference registers
  logic signed [gcd_pkg::LAT_W-1:0] ref_lat_r;
  logic signed [gcd_pkg::LON_W-1:0] ref_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= 28'sd11571006;
      ref_lon_r <= 29'sd104897023;
    end else if (cfg_we) begin
      case (cfg_index)
        gcd_pkg::REG_REF_LAT: ref_lat_r <= cfg_wdata[gcd_pkg::LAT_W-1:0];
        gcd_pkg::REG_REF_LON: ref_lon_r <= cfg_wdata[gcd_pkg::LON_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: span check and differences
  logic signed [29:0] flat_x, flon_x, rlat_x, rlon_x, dlat, dlon_raw, dlon;
  logic               err1;

  assign flat_x   = 30'(in_fix_latitude);
  assign flon_x   = 30'(in_fix_longitude);
  assign rlat_x   = 30'(ref_lat_r);
  assign rlon_x   = 30'(ref_lon_r);
  assign dlat     = flat_x - rlat_x;
  assign dlon_raw = flon_x - rlon_x;

  always_comb begin
    if (dlon_raw > gcd_pkg::LON_LIMIT) begin
      dlon = dlon_raw - gcd_pkg::FULL_TURN;
    end else if (dlon_raw < -gcd_pkg::LON_LIMIT) begin
      dlon = dlon_raw + gcd_pkg::FULL_TURN;
    end else begin
      dlon = dlon_raw;
    end
  end

  assign err1 = (flat_x > gcd_pkg::LAT_LIMIT) || (flat_x < -gcd_pkg::LAT_LIMIT) ||
                (flon_x > gcd_pkg::LON_LIMIT) || (flon_x < -gcd_pkg::LON_LIMIT) ||
                (rlat_x > gcd_pkg::LAT_LIMIT) || (rlat_x < -gcd_pkg::LAT_LIMIT) ||
                (rlon_x > gcd_pkg::LON_LIMIT) || (rlon_x < -gcd_pkg::LON_LIMIT);

  logic signed [29:0] ang1_r [4];
  gcd_pkg::tag_t      tag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r.valid <= start & ~busy;
      tag1_r.err   <= err1;
    end
  end

  // lanes: half dlat, half dlon, reference latitude, fix latitude
  always_ff @(posedge clk) begin
    ang1_r[0] <= dlat;
    ang1_r[1] <= dlon;
    ang1_r[2] <= rlat_x;
    ang1_r[3] <= flat_x;
  end

  // stage 2: microdegrees times radian scale, on magnitudes
  logic [57:0]   prod2_r [4];
  logic          neg2_r  [4];
  gcd_pkg::tag_t tag2_r;
  logic [28:0]   mag1    [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag1[i] = ang1_r[i][29] ? 29'(-ang1_r[i]) : ang1_r[i][28:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod2_r[i] <= 58'(mag1[i]) * 58'(gcd_pkg::RAD_SCALE);
      neg2_r[i]  <= ang1_r[i][29];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r <= tag1_r;
    end
  end

  // stage 3: round to Q30, half angles take one more shift
  logic signed [DW-1:0] ang3_r [4];
  logic [DW-1:0]        rad2   [4];
  gcd_pkg::tag_t        tag3_r;

  always_comb begin
    rad2[0] = DW'((prod2_r[0] + (58'(1) << 24)) >> 25);
    rad2[1] = DW'((prod2_r[1] + (58'(1) << 24)) >> 25);
    rad2[2] = DW'((prod2_r[2] + (58'(1) << 23)) >> 24);
    rad2[3] = DW'((prod2_r[3] + (58'(1) << 23)) >> 24);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ang3_r[i] <= neg2_r[i] ? -signed'(rad2[i]) : signed'(rad2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
    end else begin
      tag3_r <= tag2_r;
    end
  end

  // sine and cosine
  gcd_pkg::tag_t        rot_tag;
  logic signed [DW-1:0] rot_sin [4];
  logic signed [DW-1:0] rot_cos [4];

  gcd_cordic_rot #(
    .STAGES (CORDIC_STAGES),
    .LANES  (4)
  ) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (tag3_r),
    .in_angle (ang3_r),
    .out_tag  (rot_tag),
    .out_sin  (rot_sin),
    .out_cos  (rot_cos)
  );

  // stages 4..9: a = slat^2 + round(round(c1*c2)*slon)*slon
  logic signed [PW-1:0] ccp4_r, sq4_r;
  logic signed [DW-1:0] slon4_r;
  gcd_pkg::tag_t        tag4_r;

  always_ff @(posedge clk) begin
    ccp4_r  <= rot_cos[2] * rot_cos[3];
    sq4_r   <= rot_sin[0] * rot_sin[0];
    slon4_r <= rot_sin[1];
  end

  logic signed [DW-1:0] cc5_r, slon5_r;
  logic signed [PW-1:0] sq5_r;
  gcd_pkg::tag_t        tag5_r;

  always_ff @(posedge clk) begin
    cc5_r   <= DW'((ccp4_r + HALF_Q30) >>> 30);
    sq5_r   <= sq4_r;
    slon5_r <= slon4_r;
  end

  logic signed [PW-1:0] tp6_r, sq6_r;
  logic signed [DW-1:0] slon6_r;
  gcd_pkg::tag_t        tag6_r;

  always_ff @(posedge clk) begin
    tp6_r   <= cc5_r * slon5_r;
    sq6_r   <= sq5_r;
    slon6_r <= slon5_r;
  end

  logic signed [DW-1:0] t7_r, slon7_r;
  logic signed [PW-1:0] sq7_r;
  gcd_pkg::tag_t        tag7_r;

  always_ff @(posedge clk) begin
    t7_r    <= DW'((tp6_r + HALF_Q30) >>> 30);
    sq7_r   <= sq6_r;
    slon7_r <= slon6_r;
  end

  logic signed [PW-1:0] tsl8_r, sq8_r;
  gcd_pkg::tag_t        tag8_r;

  always_ff @(posedge clk) begin
    tsl8_r <= t7_r * slon7_r;
    sq8_r  <= sq7_r;
  end

  logic signed [PW:0]        sum8;
  logic [gcd_pkg::SQ_W-1:0]  a8;
  logic [gcd_pkg::SQ_W-1:0]  sq_in9_r [2];
  gcd_pkg::tag_t             tag9_r;

  assign sum8 = (PW+1)'(sq8_r) + (PW+1)'(tsl8_r);

  // clamp a to [0, 1]
  always_comb begin
    if (sum8[PW]) begin
      a8 = '0;
    end else if (sum8 > signed'((PW+1)'(gcd_pkg::Q60_ONE))) begin
      a8 = gcd_pkg::Q60_ONE;
    end else begin
      a8 = sum8[gcd_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sq_in9_r[0] <= a8;
    sq_in9_r[1] <= gcd_pkg::Q60_ONE - a8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag4_r <= '0;
      tag5_r <= '0;
      tag6_r <= '0;
      tag7_r <= '0;
      tag8_r <= '0;
      tag9_r <= '0;
    end else begin
      tag4_r <= rot_tag;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
      tag9_r <= tag8_r;
    end
  end

  // square roots of a and 1 - a
  gcd_pkg::tag_t            sq_tag;
  logic [gcd_pkg::RT_W-1:0] sq_root [2];

  gcd_isqrt #(
    .LANES (2)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (tag9_r),
    .in_n     (sq_in9_r),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  // central angle
  gcd_pkg::tag_t        vec_tag;
  logic signed [DW-1:0] vec_angle;

  gcd_cordic_vec #(
    .STAGES (CORDIC_STAGES)
  ) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (sq_tag),
    .in_x      (signed'(DW'(sq_root[1]))),
    .in_y      (signed'(DW'(sq_root[0]))),
    .out_tag   (vec_tag),
    .out_angle (vec_angle)
  );

  // stage 10: theta times Earth diameter
  logic [DW-2:0]  theta;
  logic [56:0]    dp10_r;
  gcd_pkg::tag_t  tag10_r;

  assign theta = vec_angle[DW-1] ? '0 : vec_angle[DW-2:0];

  always_ff @(posedge clk) begin
    dp10_r <= 57'(theta) * 57'(gcd_pkg::EARTH_DIAM_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag10_r <= '0;
    end else begin
      tag10_r <= vec_tag;
    end
  end

  // stage 11: round to metres, saturate, drop to zero on range error
  logic [26:0]                 dist_full;
  logic [gcd_pkg::DIST_W-1:0]  dist_nxt;
  logic [gcd_pkg::DIST_W-1:0]  dist_r;
  logic                        err_r;
  logic                        valid_r;

  assign dist_full = 27'((dp10_r + HALF_D) >> 30);

  always_comb begin
    if (tag10_r.err) begin
      dist_nxt = '0;
    end else if (dist_full > 27'(gcd_pkg::MAX_DISTANCE)) begin
      dist_nxt = gcd_pkg::MAX_DISTANCE;
    end else begin
      dist_nxt = dist_full[gcd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    err_r  <= tag10_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tag10_r.valid;
    end
  end

  assign out_valid       = valid_r;
  assign out_distance_m  = dist_r;
  assign out_range_error = err_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for great_circle_distance_core: a haversine predictor checks every distance word.
`timescale 1ns / 1ps
`default_nettype none

class distance_scoreboard;
  typedef struct {
    logic [24:0] dist_m;
    logic        err;
  } fix_result_t;

  fix_result_t pending[$];
  int          n_fail;
  logic [27:0] ref_lat;
  logic [28:0] ref_lon;
  longint      atan_q30[32];

  function new();
    longint tab[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};
    atan_q30 = tab;
    n_fail = 0;
    ref_lat = 28'd11571006;
    ref_lon = 29'd104897023;
  endfunction

  // Floor shift; >>> on a signed longint already floors.
  function longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function longint rad_q30(longint u, int sh);
    longint mag;
    longint r;
    mag = (u < 0) ? -u : u;
    r = (mag * 64'd314410567 + (64'd1 << (sh - 1))) >> sh;
    return (u < 0) ? -r : r;
  endfunction

  function void rotate(longint z, output longint s, output longint c);
    longint x;
    longint y;
    longint nx;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_q30[i];
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_q30[i];
      end
      x = nx;
    end
    s = y;
    c = x;
  endfunction

  function longint vector_angle(longint x, longint y);
    longint z;
    longint nx;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_q30[i];
      end else begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_q30[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function longint root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function void set_reg(bit idx, logic [28:0] v);
    if (idx == gcd_pkg::REG_REF_LAT) ref_lat = v[27:0];
    else ref_lon = v;
  endfunction

  function void note_fix(logic signed [27:0] flat_i, logic signed [28:0] flon_i);
    fix_result_t e;
    longint flat, flon, rlat, rlon, dlat, dlon;
    longint slat, slon, c1, c2, tmp, cc, t, a, th, d;
    longint one60;
    longint half30;
    one60 = 64'd1 << 60;
    half30 = 64'sd1 << 29;
    flat = flat_i;
    flon = flon_i;
    rlat = $signed(ref_lat);
    rlon = $signed(ref_lon);
    if (flat > 90000000 || flat < -90000000 || flon > 180000000 || flon < -180000000 ||
        rlat > 90000000 || rlat < -90000000 || rlon > 180000000 || rlon < -180000000) begin
      e.dist_m = '0;
      e.err = 1'b1;
    end else begin
      dlat = flat - rlat;
      dlon = flon - rlon;
      if (dlon > 180000000) dlon -= 360000000;
      else if (dlon < -180000000) dlon += 360000000;
      rotate(rad_q30(dlat, 25), slat, tmp);
      rotate(rad_q30(dlon, 25), slon, tmp);
      rotate(rad_q30(rlat, 24), tmp, c1);
      rotate(rad_q30(flat, 24), tmp, c2);
      cc = (c1 * c2 + half30) >>> 30;
      t = (cc * slon + half30) >>> 30;
      a = slat * slat + t * slon;
      if (a < 0) a = 0;
      if (a > one60) a = one60;
      th = vector_angle(root_floor(one60 - a), root_floor(a));
      if (th < 0) th = 0;
      d = (th * 2 * 6371000 + half30) >>> 30;
      if (d > 20015087) d = 20015087;
      e.dist_m = d[24:0];
      e.err = 1'b0;
    end
    pending.push_back(e);
  endfunction

  function void check_word(logic [24:0] dist_m, logic err);
    fix_result_t e;
    if (pending.size() == 0) begin
      $error("distance word with nothing pending: dist=%0d err=%0d", dist_m, err);
      n_fail++;
      return;
    end
    e = pending.pop_front();
    if (dist_m !== e.dist_m) begin
      $error("distance_m: expected %0d, got %0d", e.dist_m, dist_m);
      n_fail++;
    end
    if (err !== e.err) begin
      $error("range_error: expected %0d, got %0d", e.err, err);
      n_fail++;
    end
  endfunction
endclass

module tb;
  localparam int LAT_W  = gcd_pkg::LAT_W;
  localparam int LON_W  = gcd_pkg::LON_W;
  localparam int CFG_W  = gcd_pkg::CFG_W;
  localparam int DIST_W = gcd_pkg::DIST_W;

  localparam int LATENCY = 42 + 2 * 24;
  localparam longint CYCLE_LIMIT = 400000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic                    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    start;
  logic                    busy;
  logic signed [LAT_W-1:0] in_fix_latitude;
  logic signed [LON_W-1:0] in_fix_longitude;
  logic                    out_valid;
  logic [DIST_W-1:0]       out_distance_m;
  logic                    out_range_error;

  distance_scoreboard sb;
  longint cycle_count;
  bit     calm;

  great_circle_distance_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy),
    .in_fix_latitude(in_fix_latitude), .in_fix_longitude(in_fix_longitude),
    .out_valid(out_valid), .out_distance_m(out_distance_m),
    .out_range_error(out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) sb.check_word(out_distance_m, out_range_error);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(bit idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold start until the block takes the word; start stays high for back-to-back words.
  task automatic send_fix(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start <= 1'b1;
    in_fix_latitude <= lat;
    in_fix_longitude <= lon;
    do @(posedge clk); while (busy);
    sb.note_fix(lat, lon);
    @(negedge clk);
  endtask

  // Drop start at once: the caller stands at a falling edge.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [LAT_W-1:0] rand_lat();
    if ($urandom_range(0, 9) == 0) return LAT_W'($urandom);
    return LAT_W'($signed($urandom_range(0, 180000000)) - 90000000);
  endfunction

  function automatic logic signed [LON_W-1:0] rand_lon();
    if ($urandom_range(0, 9) == 0) return LON_W'($urandom);
    return LON_W'($signed($urandom_range(0, 360000000)) - 180000000);
  endfunction

  initial begin
    sb = new();
    cycle_count = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gcd_pkg::REG_REF_LAT;
    cfg_wdata = '0;
    start = 1'b0;
    in_fix_latitude = '0;
    in_fix_longitude = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: span edges, just outside, field extremes, same point, antipode.
    send_fix(28'sd11571006, 29'sd104897023);
    send_fix(28'sd90000000, 29'sd0);
    send_fix(-28'sd90000000, 29'sd0);
    send_fix(28'sd90000001, 29'sd0);
    send_fix(-28'sd90000001, 29'sd0);
    send_fix(28'sd0, 29'sd180000000);
    send_fix(28'sd0, -29'sd180000000);
    send_fix(28'sd0, 29'sd180000001);
    send_fix(28'sd0, -29'sd180000001);
    send_fix(28'sh7FFFFFF, 29'sh0FFFFFFF);
    send_fix(28'sh8000000, 29'sh10000000);
    send_fix(-28'sd11571006, -29'sd75102977);
    send_fix(28'sd0, 29'sd0);
    send_fix(28'sd1, -29'sd1);
    drain();

    write_reg(gcd_pkg::REG_REF_LAT, 29'(90000000));
    write_reg(gcd_pkg::REG_REF_LON, 29'(-180000000));
    send_fix(-28'sd90000000, 29'sd180000000);
    send_fix(28'sd90000000, -29'sd180000000);
    send_fix(28'sd0, 29'sd0);
    drain();
    // Reference out of span.
    write_reg(gcd_pkg::REG_REF_LAT, 29'(90000001));
    send_fix(28'sd0, 29'sd0);
    drain();
    write_reg(gcd_pkg::REG_REF_LAT, 29'(-90000000));
    write_reg(gcd_pkg::REG_REF_LON, 29'(180000001));
    send_fix(28'sd0, 29'sd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gcd_pkg::REG_REF_LAT, (ph == 5) ? 29'(11571006) : 29'(rand_lat()));
      write_reg(gcd_pkg::REG_REF_LON, (ph == 5) ? 29'(104897023) : 29'(rand_lon()));
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < 105; k++) send_fix(rand_lat(), rand_lon());
      drain();
    end
    repeat (LATENCY + 10) @(negedge clk);

    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
